@@ design/meter_bus_long_frame_receiver_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the M-Bus long frame receiver
// Shared helpers for concurrent checks on a clock with synchronous reset.
// ----------------------------------------------------------------------------
`ifndef METER_BUS_LONG_FRAME_RECEIVER_MACROS_SVH
`define METER_BUS_LONG_FRAME_RECEIVER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MBFLR_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define MBFLR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/mbflr_pkg.sv @@
// ----------------------------------------------------------------------------
// M-Bus long frame receiver package
// Codes, line constants and the result record shared by the design files.
// ----------------------------------------------------------------------------
package mbflr_pkg;

  // Line bytes of the protocol.
  localparam logic [7:0] START_BYTE = 8'h68;
  localparam logic [7:0] STOP_BYTE  = 8'h16;
  localparam logic [7:0] ACK_BYTE   = 8'hE5;

  // First data byte that carries the slave id.
  localparam logic [7:0] ID_FIRST_POS = 8'd3;

  // Checksum and stop bytes that follow the data in the down-count.
  localparam logic [8:0] TRAILER_COUNT = 9'd2;

  // Configuration register indexes.
  localparam int unsigned CFG_INDEX_W = 1;
  localparam logic [CFG_INDEX_W-1:0] CFG_SECONDARY_MODE = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] CFG_EXPECTED_ID    = 1'b1;

  // Item operations.
  typedef enum logic [1:0] {
    OP_BYTE      = 2'd0,
    OP_ARM_ACK   = 2'd1,
    OP_ARM_FRAME = 2'd2
  } op_t;

  // Top phase; the value is also the reported status.
  typedef enum logic [2:0] {
    TOP_IDLE       = 3'd0,
    TOP_WAIT_ACK   = 3'd1,
    TOP_WAIT_FRAME = 3'd2,
    TOP_ACK_SEEN   = 3'd3,
    TOP_FRAME_GOOD = 3'd4,
    TOP_BAD_ID     = 3'd5
  } top_phase_t;

  // Position inside a long frame.
  typedef enum logic [2:0] {
    FP_HUNT   = 3'd0,
    FP_LEN1   = 3'd1,
    FP_LEN2   = 3'd2,
    FP_START2 = 3'd3,
    FP_DATA   = 3'd4,
    FP_STOP   = 3'd5
  } frame_phase_t;

  // One result item.
  typedef struct packed {
    logic [2:0]  status;
    logic        byte_kept;
    logic [7:0]  kept_byte;
    logic        frame_end;
    logic [31:0] slave_id;
  } result_t;

endpackage

@@ design/mbflr_if.sv @@
// ----------------------------------------------------------------------------
// M-Bus long frame receiver channels
// Valid/ready channels for the input items and the result items.
// ----------------------------------------------------------------------------

// Input channel: a line byte or an arm command.
interface mbflr_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] op;
  logic [7:0] data_byte;

  modport source (output valid, output op, output data_byte, input ready);
  modport sink   (input valid, input op, input data_byte, output ready);
endinterface

// Result channel: one result per input item.
interface mbflr_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic        byte_kept;
  logic [7:0]  kept_byte;
  logic        frame_end;
  logic [31:0] slave_id;

  modport source (output valid, output status, output byte_kept, output kept_byte,
                  output frame_end, output slave_id, input ready);
  modport sink   (input valid, input status, input byte_kept, input kept_byte,
                  input frame_end, input slave_id, output ready);
endinterface

@@ design/meter_bus_long_frame_receiver.sv @@
// Path: an accepted item goes to the input register, then through the parser
// logic into the result register.
// Throughput: one item per cycle while the output is ready; while a finished
// result waits on a stalled output, the input register takes one more item
// and then holds off the input. Reset: synchronous rst_n clears both valid
// flags, the receive state and the configuration registers.
// ----------------------------------------------------------------------------
// M-Bus long frame receiver
// Parses acknowledges and long response frames byte by byte, one result each.
// ----------------------------------------------------------------------------
module meter_bus_long_frame_receiver import mbflr_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  mbflr_in_if.sink               in_ch,
  mbflr_out_if.source            out_ch,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [31:0]            cfg_wdata
);

  logic        secondary_mode_r;
  logic [31:0] expected_id_r;
  logic        st_valid_r;
  logic [1:0]  st_op_r;
  logic [7:0]  st_byte_r;
  logic        out_valid_r;
  result_t     out_res_r;
  result_t     step_res;
  logic        advance;
  logic        in_xfer;

  // The input register moves on when the result register is free or drains.
  assign advance = st_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !st_valid_r || advance;
  assign in_xfer = in_ch.valid && in_ch.ready;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      secondary_mode_r <= 1'b0;
      expected_id_r    <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SECONDARY_MODE: secondary_mode_r <= cfg_wdata[0];
        CFG_EXPECTED_ID:    expected_id_r    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      st_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      st_op_r   <= in_ch.op;
      st_byte_r <= in_ch.data_byte;
    end
  end

  // Parser state and per-item logic.
  mbflr_parser u_parser (
    .clk            (clk),
    .rst_n          (rst_n),
    .step_en        (advance),
    .op             (st_op_r),
    .data_byte      (st_byte_r),
    .secondary_mode (secondary_mode_r),
    .expected_id    (expected_id_r),
    .res            (step_res)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res_r <= step_res;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.status    = out_res_r.status;
  assign out_ch.byte_kept = out_res_r.byte_kept;
  assign out_ch.kept_byte = out_res_r.kept_byte;
  assign out_ch.frame_end = out_res_r.frame_end;
  assign out_ch.slave_id  = out_res_r.slave_id;

endmodule

@@ design/mbflr_parser.sv @@
// ----------------------------------------------------------------------------
// M-Bus frame parser
// Holds the receive state and computes the result of one item per step.
// ----------------------------------------------------------------------------
module mbflr_parser import mbflr_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        step_en,
  input  logic [1:0]  op,
  input  logic [7:0]  data_byte,
  input  logic        secondary_mode,
  input  logic [31:0] expected_id,
  output result_t     res
);

  top_phase_t   top_r, top_nxt;
  frame_phase_t fp_r, fp_nxt;
  logic [8:0]   rem_r, rem_nxt;
  logic [7:0]   sum_r, sum_nxt;
  logic [7:0]   pos_r, pos_nxt;
  logic [31:0]  id_r, id_nxt;
  logic         kept;
  logic         frame_end;

  // Next state for one item.
  always_comb begin
    top_nxt = top_r;
    fp_nxt  = fp_r;
    rem_nxt = rem_r;
    sum_nxt = sum_r;
    pos_nxt = pos_r;
    id_nxt  = id_r;
    unique case (op)
      OP_ARM_ACK, OP_ARM_FRAME: begin
        top_nxt = (op == OP_ARM_ACK) ? TOP_WAIT_ACK : TOP_WAIT_FRAME;
        fp_nxt  = FP_HUNT;
        rem_nxt = '0;
        sum_nxt = '0;
        pos_nxt = '0;
        id_nxt  = '0;
      end
      OP_BYTE: begin
        if (top_r == TOP_WAIT_ACK) begin
          if (data_byte == ACK_BYTE) begin
            top_nxt = TOP_ACK_SEEN;
            fp_nxt  = FP_HUNT;
          end
        end else if (top_r == TOP_WAIT_FRAME) begin
          unique case (fp_r)
            FP_HUNT: begin
              sum_nxt = '0;
              pos_nxt = '0;
              id_nxt  = '0;
              if (data_byte == START_BYTE) begin
                fp_nxt = FP_LEN1;
              end
            end
            FP_LEN1: begin
              rem_nxt = {1'b0, data_byte};
              fp_nxt  = FP_LEN2;
            end
            FP_LEN2: begin
              fp_nxt = (rem_r == {1'b0, data_byte}) ? FP_START2 : FP_HUNT;
            end
            FP_START2: begin
              if (data_byte == START_BYTE) begin
                rem_nxt = rem_r + TRAILER_COUNT;
                fp_nxt  = FP_DATA;
              end else begin
                fp_nxt = FP_HUNT;
              end
            end
            FP_DATA: begin
              if (rem_r > TRAILER_COUNT) begin
                sum_nxt = sum_r + data_byte;
                // Data bytes three to six build the slave id, low byte first.
                case (pos_r - ID_FIRST_POS)
                  8'd0: id_nxt[7:0]   = id_r[7:0]   | data_byte;
                  8'd1: id_nxt[15:8]  = id_r[15:8]  | data_byte;
                  8'd2: id_nxt[23:16] = id_r[23:16] | data_byte;
                  8'd3: id_nxt[31:24] = id_r[31:24] | data_byte;
                  default: ;
                endcase
                pos_nxt = pos_r + 8'd1;
                rem_nxt = rem_r - 9'd1;
              end else if (data_byte == sum_r) begin
                fp_nxt = FP_STOP;
              end else begin
                fp_nxt = FP_HUNT;
              end
            end
            FP_STOP: begin
              if (data_byte == STOP_BYTE) begin
                top_nxt = (secondary_mode && (id_r != expected_id)) ?
                          TOP_BAD_ID : TOP_FRAME_GOOD;
              end
              fp_nxt = FP_HUNT;
            end
            default: fp_nxt = FP_HUNT;
          endcase
        end
      end
      default: ;
    endcase
  end

  // Which bytes the frame keeps.
  always_comb begin
    kept      = 1'b0;
    frame_end = 1'b0;
    if ((op == OP_BYTE) && (top_r == TOP_WAIT_FRAME)) begin
      unique case (fp_r)
        FP_HUNT:   kept = (data_byte == START_BYTE);
        FP_LEN1:   kept = 1'b1;
        FP_LEN2:   kept = (rem_r == {1'b0, data_byte});
        FP_START2: kept = (data_byte == START_BYTE);
        FP_DATA:   kept = (rem_r > TRAILER_COUNT) || (data_byte == sum_r);
        FP_STOP: begin
          kept      = (data_byte == STOP_BYTE);
          frame_end = (data_byte == STOP_BYTE);
        end
        default: kept = 1'b0;
      endcase
    end
  end

  // Result of the current item.
  always_comb begin
    res.status    = top_nxt;
    res.byte_kept = kept;
    res.kept_byte = kept ? data_byte : 8'd0;
    res.frame_end = frame_end;
    res.slave_id  = id_nxt;
  end

  // State registers advance once per item.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      top_r <= TOP_IDLE;
      fp_r  <= FP_HUNT;
      rem_r <= '0;
      sum_r <= '0;
      pos_r <= '0;
      id_r  <= '0;
    end else if (step_en) begin
      top_r <= top_nxt;
      fp_r  <= fp_nxt;
      rem_r <= rem_nxt;
      sum_r <= sum_nxt;
      pos_r <= pos_nxt;
      id_r  <= id_nxt;
    end
  end

endmodule

@@ design/mbflr_checker.sv @@
// ----------------------------------------------------------------------------
// M-Bus long frame receiver checker
// Port-level checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`include "meter_bus_long_frame_receiver_macros.svh"

module mbflr_checker import mbflr_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  out_status,
  input logic        out_byte_kept,
  input logic [7:0]  out_kept_byte,
  input logic        out_frame_end,
  input logic [31:0] out_slave_id
);

  // A stalled result holds its valid and its payload.
  `MBFLR_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable({out_status, out_byte_kept, out_kept_byte, out_frame_end, out_slave_id}), "stalled result changed")

  // A frame ends only on a kept stop byte.
  `MBFLR_ASSERT_IMPL(a_end_stop, clk, rst_n, out_valid && out_frame_end, out_byte_kept && (out_kept_byte == STOP_BYTE), "frame end without kept stop byte")

  // A frame end always reports a frame verdict.
  `MBFLR_ASSERT_IMPL(a_end_status, clk, rst_n, out_valid && out_frame_end, (out_status == TOP_FRAME_GOOD) || (out_status == TOP_BAD_ID), "frame end without verdict")

  // A byte that is not kept reads as zero.
  `MBFLR_ASSERT_IMPL(a_drop_zero, clk, rst_n, out_valid && !out_byte_kept, (out_kept_byte == 8'd0) && !out_frame_end, "dropped byte not zero")

endmodule

bind meter_bus_long_frame_receiver mbflr_checker u_mbflr_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .out_status    (out_ch.status),
  .out_byte_kept (out_ch.byte_kept),
  .out_kept_byte (out_ch.kept_byte),
  .out_frame_end (out_ch.frame_end),
  .out_slave_id  (out_ch.slave_id)
);

@@ bench/tb_meter_bus_long_frame_receiver.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the M-Bus long frame receiver
// Drives acknowledge and long-frame traffic with random gaps and checks every
// result against a cycle-free model of the parser kept in a small class.
// ----------------------------------------------------------------------------
module tb_meter_bus_long_frame_receiver;
  import mbflr_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam int unsigned SETTLE_COUNT = 8;
  localparam int unsigned DIRECTED_N   = 25;
  localparam int unsigned PHASE_ITEMS  = 255;
  localparam int unsigned PHASE_COUNT  = 5;
  localparam int unsigned REPORT_MAX   = 10;
  localparam logic [1:0]  OP_UNDEFINED = 2'd3;
  localparam logic [7:0]  ID_LAST_POS  = ID_FIRST_POS + 8'd3;

  // Ways a generated frame can be broken on purpose.
  typedef enum int {
    FLAW_NONE, FLAW_LEN2, FLAW_START2, FLAW_SUM, FLAW_STOP, FLAW_ID
  } flaw_t;

  // Parser model: own copy of the receive state and the registers, plus the
  // queue of results still owed by the block.
  class frame_result_checker;
    bit             secondary_mode;
    logic [31:0]    expected_id;
    top_phase_t     top_phase;
    frame_phase_t   frame_phase;
    logic [8:0]     remaining;
    logic [7:0]     running_sum;
    logic [7:0]     data_pos;
    logic [31:0]    gathered_id;
    result_t        expected_results[$];
    int unsigned    mismatches;

    function new();
      secondary_mode = 1'b0;
      expected_id    = '0;
      top_phase      = TOP_IDLE;
      mismatches     = 0;
      clear_frame();
    endfunction

    function void clear_frame();
      frame_phase = FP_HUNT;
      remaining   = '0;
      running_sum = '0;
      data_pos    = '0;
      gathered_id = '0;
    endfunction

    function void write_register(logic [CFG_INDEX_W-1:0] index, logic [31:0] value);
      if (index == CFG_SECONDARY_MODE) begin
        secondary_mode = value[0];
      end else if (index == CFG_EXPECTED_ID) begin
        expected_id = value;
      end
    endfunction

    // Works out the result of one accepted item and queues it.
    function void accept_item(logic [1:0] op, logic [7:0] line_byte);
      result_t exp;
      bit      kept;
      bit      at_end;
      kept   = 1'b0;
      at_end = 1'b0;
      case (op)
        OP_ARM_ACK: begin
          top_phase = TOP_WAIT_ACK;
          clear_frame();
        end
        OP_ARM_FRAME: begin
          top_phase = TOP_WAIT_FRAME;
          clear_frame();
        end
        OP_BYTE: begin
          if (top_phase == TOP_WAIT_ACK) begin
            if (line_byte == ACK_BYTE) begin
              top_phase   = TOP_ACK_SEEN;
              frame_phase = FP_HUNT;
            end
          end else if (top_phase == TOP_WAIT_FRAME) begin
            case (frame_phase)
              FP_HUNT: begin
                running_sum = '0;
                data_pos    = '0;
                gathered_id = '0;
                if (line_byte == START_BYTE) begin
                  kept        = 1'b1;
                  frame_phase = FP_LEN1;
                end
              end
              FP_LEN1: begin
                remaining   = {1'b0, line_byte};
                kept        = 1'b1;
                frame_phase = FP_LEN2;
              end
              FP_LEN2: begin
                if (remaining == {1'b0, line_byte}) begin
                  kept        = 1'b1;
                  frame_phase = FP_START2;
                end else begin
                  frame_phase = FP_HUNT;
                end
              end
              FP_START2: begin
                if (line_byte == START_BYTE) begin
                  remaining   = remaining + TRAILER_COUNT;
                  kept        = 1'b1;
                  frame_phase = FP_DATA;
                end else begin
                  frame_phase = FP_HUNT;
                end
              end
              FP_DATA: begin
                if (remaining > TRAILER_COUNT) begin
                  kept        = 1'b1;
                  running_sum = running_sum + line_byte;
                  if (data_pos >= ID_FIRST_POS && data_pos <= ID_LAST_POS) begin
                    gathered_id = gathered_id |
                                  (32'(line_byte) << (8 * (data_pos - ID_FIRST_POS)));
                  end
                  data_pos  = data_pos + 8'd1;
                  remaining = remaining - 9'd1;
                end else if (line_byte == running_sum) begin
                  kept        = 1'b1;
                  frame_phase = FP_STOP;
                end else begin
                  frame_phase = FP_HUNT;
                end
              end
              FP_STOP: begin
                if (line_byte == STOP_BYTE) begin
                  kept   = 1'b1;
                  at_end = 1'b1;
                  if (secondary_mode && gathered_id != expected_id) begin
                    top_phase = TOP_BAD_ID;
                  end else begin
                    top_phase = TOP_FRAME_GOOD;
                  end
                end
                frame_phase = FP_HUNT;
              end
              default: begin
                frame_phase = FP_HUNT;
              end
            endcase
          end
        end
        default: begin
        end
      endcase
      exp.status    = top_phase;
      exp.byte_kept = kept;
      exp.kept_byte = kept ? line_byte : 8'h00;
      exp.frame_end = at_end;
      exp.slave_id  = gathered_id;
      expected_results.push_back(exp);
    endfunction

    // Compares one result transfer with the oldest expectation.
    function void compare_result(result_t got);
      result_t exp;
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX) begin
          $display("Unexpected result: status %0d kept %0b byte %02h end %0b id %08h",
                   got.status, got.byte_kept, got.kept_byte, got.frame_end, got.slave_id);
        end
        return;
      end
      exp = expected_results.pop_front();
      if (got.status !== exp.status || got.byte_kept !== exp.byte_kept ||
          got.kept_byte !== exp.kept_byte || got.frame_end !== exp.frame_end ||
          got.slave_id !== exp.slave_id) begin
        mismatches++;
        if (mismatches <= REPORT_MAX) begin
          $display("Result mismatch: expected status %0d kept %0b byte %02h end %0b id %08h",
                   exp.status, exp.byte_kept, exp.kept_byte, exp.frame_end, exp.slave_id);
          $display("                 actual   status %0d kept %0b byte %02h end %0b id %08h",
                   got.status, got.byte_kept, got.kept_byte, got.frame_end, got.slave_id);
        end
      end
    endfunction
  endclass

  logic                   clk;
  logic                   rst_n;
  logic                   cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [31:0]            cfg_wdata;
  logic                   out_gaps;
  logic                   out_hold;
  logic                   hold_go;
  bit                     in_gaps;
  int unsigned            items_sent;
  int unsigned            cycle_count;
  frame_result_checker    rx_model;

  mbflr_in_if  in_ch ();
  mbflr_out_if out_ch ();

  meter_bus_long_frame_receiver i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // Clock, 10 ns period.
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Run limit.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Result side ready: random gaps, a quiet stretch, or the long hold-off.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (out_hold) begin
      out_ch.ready <= 1'b0;
    end else if (out_gaps) begin
      out_ch.ready <= ($urandom_range(99) >= 25);
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // Long receiver hold-off, counted here so the sender keeps offering items.
  initial begin
    out_hold = 1'b0;
    wait (hold_go);
    @(posedge clk);
    out_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    out_hold <= 1'b0;
  end

  // Transfer monitor: results are checked before the same edge's input is noted.
  always @(posedge clk) begin
    result_t seen;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        seen.status    = out_ch.status;
        seen.byte_kept = out_ch.byte_kept;
        seen.kept_byte = out_ch.kept_byte;
        seen.frame_end = out_ch.frame_end;
        seen.slave_id  = out_ch.slave_id;
        rx_model.compare_result(seen);
      end
      if (in_ch.valid && in_ch.ready) begin
        rx_model.accept_item(in_ch.op, in_ch.data_byte);
      end
    end
  end

  // Offers one item, with random idle cycles first, and waits for its transfer.
  task automatic send_item(input logic [1:0] op, input logic [7:0] line_byte);
    while (in_gaps && $urandom_range(99) < 25) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.op        <= op;
    in_ch.data_byte <= line_byte;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    items_sent++;
  endtask

  // Writes one register; only called while nothing is in flight.
  task automatic write_register(input logic [CFG_INDEX_W-1:0] index,
                                input logic [31:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= index;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    rx_model.write_register(index, value);
    @(posedge clk);
  endtask

  // Stops offering and waits until every owed result has come out. It first
  // lets the monitor note the last accepted item.
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (rx_model.expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE_COUNT) @(posedge clk);
  endtask

  function automatic logic [7:0] nonzero_byte();
    return 8'($urandom_range(255, 1));
  endfunction

  // Mostly short frames, now and then longer ones, rarely the longest.
  function automatic int pick_length();
    int roll;
    roll = $urandom_range(99);
    if (roll == 0) begin
      return 255;
    end else if (roll < 75) begin
      return $urandom_range(12);
    end
    return $urandom_range(40, 13);
  endfunction

  function automatic flaw_t pick_flaw();
    if ($urandom_range(99) < 80) begin
      return FLAW_NONE;
    end
    return flaw_t'($urandom_range(5, 1));
  endfunction

  // Sends a whole long frame; id bytes mostly follow the configured id unless broken.
  task automatic send_frame(input int len, input flaw_t flaw);
    logic [7:0] body[$];
    logic [7:0] csum;
    logic [7:0] value;
    logic [7:0] second_start;
    int         k;
    csum = '0;
    for (k = 0; k < len; k++) begin
      value = 8'($urandom_range(255));
      if (k >= ID_FIRST_POS && k <= ID_LAST_POS && $urandom_range(9) != 0) begin
        value = rx_model.expected_id[8 * (k - ID_FIRST_POS) +: 8];
        if (flaw == FLAW_ID && k == ID_FIRST_POS) begin
          value = value ^ nonzero_byte();
        end
      end
      body.push_back(value);
      csum = csum + value;
    end
    second_start = START_BYTE ^ nonzero_byte();
    send_item(OP_BYTE, START_BYTE);
    send_item(OP_BYTE, 8'(len));
    send_item(OP_BYTE, (flaw == FLAW_LEN2) ? 8'(len) ^ nonzero_byte() : 8'(len));
    send_item(OP_BYTE, (flaw == FLAW_START2) ? second_start : START_BYTE);
    foreach (body[k]) send_item(OP_BYTE, body[k]);
    send_item(OP_BYTE, (flaw == FLAW_SUM) ? csum ^ nonzero_byte() : csum);
    send_item(OP_BYTE, (flaw == FLAW_STOP) ? STOP_BYTE ^ nonzero_byte() : STOP_BYTE);
  endtask

  // One random sequence: mostly armed frames, else acknowledges, unarmed frames or noise.
  task automatic send_random_sequence();
    int pick;
    int n;
    int k;
    pick = $urandom_range(99);
    if (pick < 60) begin
      send_item(OP_ARM_FRAME, 8'($urandom_range(255)));
      n = $urandom_range(2);
      for (k = 0; k < n; k++) send_item(OP_BYTE, 8'($urandom_range(255)));
      send_frame(pick_length(), pick_flaw());
    end else if (pick < 75) begin
      send_item(OP_ARM_ACK, 8'($urandom_range(255)));
      n = $urandom_range(3);
      for (k = 0; k < n; k++) send_item(OP_BYTE, 8'($urandom_range(255)));
      if ($urandom_range(3) != 0) begin
        send_item(OP_BYTE, ACK_BYTE);
      end
      send_item(OP_BYTE, 8'($urandom_range(255)));
    end else if (pick < 85) begin
      send_frame(pick_length(), pick_flaw());
    end else begin
      n = $urandom_range(4, 1);
      for (k = 0; k < n; k++) begin
        send_item(2'($urandom_range(3)), 8'($urandom_range(255)));
      end
    end
  endtask

  // Main sequence.
  initial begin
    int unsigned phase;
    logic [31:0] id_value;
    rx_model        = new();
    rst_n           = 1'b0;
    cfg_we          = 1'b0;
    cfg_index       = '0;
    cfg_wdata       = '0;
    in_ch.valid     = 1'b0;
    in_ch.op        = OP_BYTE;
    in_ch.data_byte = '0;
    out_gaps        = 1'b1;
    hold_go         = 1'b0;
    in_gaps         = 1'b1;
    items_sent      = 0;
    cycle_count     = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: undefined op, bytes while idle, acknowledge, good empty frame,
    // length and second start mismatches, re-arming in mid-frame.
    send_item(OP_UNDEFINED, 8'hA5);
    send_item(OP_BYTE, 8'h00);
    send_item(OP_ARM_ACK, 8'h00);
    send_item(OP_BYTE, 8'hFF);
    send_item(OP_BYTE, ACK_BYTE);
    send_item(OP_BYTE, ACK_BYTE);
    send_item(OP_ARM_FRAME, 8'hFF);
    send_item(OP_BYTE, 8'h00);
    send_item(OP_BYTE, START_BYTE);
    send_item(OP_BYTE, 8'h03);
    send_item(OP_BYTE, 8'h04);
    send_frame(0, FLAW_NONE);
    send_item(OP_BYTE, START_BYTE);
    send_item(OP_ARM_FRAME, 8'h00);
    send_item(OP_BYTE, START_BYTE);
    send_item(OP_BYTE, 8'h01);
    send_item(OP_BYTE, 8'h01);
    send_item(OP_BYTE, 8'hFF);
    send_item(OP_ARM_ACK, 8'hFF);
    send_item(OP_ARM_FRAME, 8'h00);

    // Random phases, each under its own register setting.
    for (phase = 0; phase < PHASE_COUNT; phase++) begin
      drain_results();
      case (phase)
        0: id_value = $urandom();
        1: id_value = 32'hFFFF_FFFF;
        2: id_value = 32'h0000_0000;
        3: id_value = 32'h0000_0000;
        default: id_value = $urandom();
      endcase
      write_register(CFG_SECONDARY_MODE, {31'd0, phase != 2 && phase != 4});
      write_register(CFG_EXPECTED_ID, id_value);
      // The second phase runs without any idle cycles on either side.
      in_gaps  = (phase != 1);
      out_gaps <= (phase != 1);
      if (phase == 2) begin
        hold_go <= 1'b1;
        send_item(OP_ARM_FRAME, 8'h00);
        send_frame(255, FLAW_NONE);
      end
      while (items_sent < DIRECTED_N + (phase + 1) * PHASE_ITEMS) begin
        send_random_sequence();
      end
    end

    drain_results();
    if (rx_model.mismatches == 0 && rx_model.expected_results.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
